// ----- sv/ushz_pkg.sv -----
// Shared types and constants of the unitary similarity hermitianize block.
`default_nettype none
package ushz_pkg;
   typedef enum logic [1:0] {
      ACT_LOAD_U  = 2'd0,
      ACT_WRITE_M = 2'd1,
      ACT_XFORM   = 2'd2,
      ACT_HERM    = 2'd3
   } action_type;

   typedef struct packed {
      logic signed [31:0] im;
      logic signed [31:0] re;
   } cval_type;

   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 72;
endpackage
`default_nettype wire

// ----- sv/unitary_similarity_hermitianize.sv -----
// Top level: complex matrix bank with unitary similarity and hermitianize.
//
//  channel | direction | handshake                 | payload
//  req_    | in        | req_tvalid / req_tready   | action, set, index, row, col, value
//  rsp_    | out       | rsp_tvalid / rsp_tready   | set, index, row, col, result, tlast
//
// Loads and writes are accepted and stored in idle.
// A hermitianize first forms H into the partial store for every entry, then
// emits each entry from there.
// A transform first forms the two products P = U^H M and Y = P U;
// each complex multiply-accumulate is a registered memory read, then an
// accumulate, through a single shared MAC, plus one write per entry.
// Emitting entries waits on rsp_tready; req_tready is low while busy.
// Reset is synchronous, active high; it clears control state only. Memory
// contents are undefined until written.
`default_nettype none
module unitary_similarity_hermitianize #(
   parameter int MATRIX_SIZE   = 4,
   parameter int NUM_MATRICES  = 8,
   parameter int FRACTION_BITS = 24
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // action[1:0], which_set[2], matrix_index[5:3], row[7:6], column[9:8],
   // value_re[41:10], value_im[73:42], zero fill
   input  wire  [ushz_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // set_out[0], index_out[3:1], row_out[5:4], column_out[7:6],
   // result_re[39:8], result_im[71:40]
   output logic [ushz_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);
   import ushz_pkg::*;

   localparam int N   = MATRIX_SIZE;
   localparam int SQ  = N * N;
   localparam int IW  = $clog2(N);
   localparam int SQW = $clog2(SQ);
   localparam int MIW = $clog2(NUM_MATRICES) > 0 ? $clog2(NUM_MATRICES) : 1;
   localparam int MD  = 2 * NUM_MATRICES * SQ;
   localparam int MAW = $clog2(MD);
   localparam logic [IW-1:0] NMAX = IW'(N - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_RD, S_MUL_ACC, S_MUL_WR, S_HRD_A, S_HRD_B, S_HCALC,
      S_HWR, S_ERD, S_EMIT
   } state_type;

   // memories
   cval_type u_mem [SQ];
   cval_type m_mem [MD];
   cval_type p_mem [SQ];
   cval_type u_rd_ff, m_rd_ff, p_rd_ff;
   logic [SQW-1:0] u_ra, p_ra;
   logic [MAW-1:0] m_ra;
   logic u_we, m_we, p_we;
   logic [SQW-1:0] u_wa, p_wa;
   logic [MAW-1:0] m_wa;
   cval_type u_wd, m_wd, p_wd;

   always_ff @(posedge clock) begin
      if (u_we) u_mem[u_wa] <= u_wd;
      if (m_we) m_mem[m_wa] <= m_wd;
      if (p_we) p_mem[p_wa] <= p_wd;
      u_rd_ff <= u_mem[u_ra];
      m_rd_ff <= m_mem[m_ra];
      p_rd_ff <= p_mem[p_ra];
   end

   // request fields
   wire [1:0]  f_act = req_tdata[1:0];
   wire        f_set = req_tdata[2];
   wire [2:0]  f_idx = req_tdata[5:3];
   wire [1:0]  f_row = req_tdata[7:6];
   wire [1:0]  f_col = req_tdata[9:8];
   cval_type   f_val;
   assign f_val.re = req_tdata[41:10];
   assign f_val.im = req_tdata[73:42];

   state_type      state_ff;
   logic           pass_ff;      // 0: P = U^H M, 1: Y = P U (into matrix)
   logic           set_ff;
   logic [MIW-1:0] idx_ff;
   logic [IW-1:0]  i_ff, j_ff, k_ff;
   logic signed [63:0] sre_ff, sim_ff;
   cval_type       a_ff, h_ff;

   function automatic logic [SQW-1:0] pos(input logic [IW-1:0] r, input logic [IW-1:0] c);
      return SQW'(32'(r) * 32'(N) + 32'(c));
   endfunction

   logic [MAW-1:0] mbase;
   assign mbase = MAW'((32'(set_ff) * 32'(NUM_MATRICES) + 32'(idx_ff)) * 32'(SQ));

   function automatic logic signed [63:0] rprod(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + (64'sd1 <<< (FRACTION_BITS - 1));
      return p >>> FRACTION_BITS;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (x < -64'sh80000000) return -32'sh80000000;
      return x[31:0];
   endfunction

   // read addresses: pass 0 reads U(k,i), M(k,j); pass 1 reads P(i,k), U(k,j)
   always_comb begin
      u_ra = pass_ff ? pos(k_ff, j_ff) : pos(k_ff, i_ff);
      p_ra = (state_ff == S_ERD || state_ff == S_EMIT) ? pos(i_ff, j_ff) : pos(i_ff, k_ff);
      m_ra = mbase + MAW'(pos(k_ff, j_ff));
      if (state_ff == S_HRD_A || state_ff == S_IDLE) m_ra = mbase + MAW'(pos(i_ff, j_ff));
      if (state_ff == S_HRD_B) m_ra = mbase + MAW'(pos(j_ff, i_ff));
   end

   // MAC operands: a (maybe conjugated) times b
   cval_type op_a, op_b;
   logic signed [63:0] t_rr, t_ii, t_ri, t_ir;
   always_comb begin
      op_a = pass_ff ? p_rd_ff : u_rd_ff;
      op_b = pass_ff ? u_rd_ff : m_rd_ff;
      t_rr = rprod(op_a.re, op_b.re);
      t_ii = rprod(op_a.im, op_b.im);
      t_ri = rprod(op_a.re, op_b.im);
      t_ir = rprod(op_a.im, op_b.re);
   end

   logic signed [63:0] hre_w, him_w;
   always_comb begin
      hre_w = (64'(a_ff.re) + 64'(m_rd_ff.re) + 64'sd1) >>> 1;
      him_w = (64'(a_ff.im) - 64'(m_rd_ff.im) + 64'sd1) >>> 1;
   end

   // write ports
   always_comb begin
      u_we = 1'b0; u_wa = pos(IW'(f_row), IW'(f_col)); u_wd = f_val;
      m_we = 1'b0; m_wa = MAW'(32'(f_set) * 32'(NUM_MATRICES) * 32'(SQ)
                        + 32'(f_idx) * 32'(SQ) + 32'(pos(IW'(f_row), IW'(f_col))));
      m_wd = f_val;
      p_we = 1'b0; p_wa = pos(i_ff, j_ff);
      p_wd.re = sat32(sre_ff); p_wd.im = sat32(sim_ff);
      if (state_ff == S_IDLE && req_tvalid && 32'(f_row) < N && 32'(f_col) < N) begin
         if (f_act == ACT_LOAD_U) u_we = 1'b1;
         if (f_act == ACT_WRITE_M && 32'(f_idx) < NUM_MATRICES) m_we = 1'b1;
      end
      if (state_ff == S_MUL_WR) begin
         if (pass_ff) begin
            m_we = 1'b1; m_wa = mbase + MAW'(pos(i_ff, j_ff)); m_wd = p_wd;
         end else begin
            p_we = 1'b1;
         end
      end
      if (state_ff == S_HWR) begin
         p_we = 1'b1; p_wd = h_ff;
      end
      if (state_ff == S_EMIT && !rsp_tvalid) begin
         m_we = 1'b1; m_wa = mbase + MAW'(pos(i_ff, j_ff)); m_wd = p_rd_ff;
      end
   end

   // Hermitian part is formed from a Y that must stay intact until every
   // pair is read, so H goes to the partial store first; the emit pass then
   // copies each entry back into the matrix as it presents the transaction.
   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_tvalid <= 1'b0;
         pass_ff    <= 1'b0;
         i_ff <= '0; j_ff <= '0; k_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && (f_act == ACT_XFORM || f_act == ACT_HERM)
                   && 32'(f_idx) < NUM_MATRICES) begin
                  set_ff <= f_set;
                  idx_ff <= MIW'(f_idx);
                  i_ff <= '0; j_ff <= '0; k_ff <= '0;
                  pass_ff <= 1'b0;
                  sre_ff <= '0; sim_ff <= '0;
                  state_ff <= (f_act == ACT_XFORM) ? S_MUL_RD : S_HRD_A;
               end
            end
            S_MUL_RD: state_ff <= S_MUL_ACC;
            S_MUL_ACC: begin
               if (pass_ff) begin
                  sre_ff <= sre_ff + t_rr - t_ii;
                  sim_ff <= sim_ff + t_ri + t_ir;
               end else begin
                  sre_ff <= sre_ff + t_rr + t_ii;
                  sim_ff <= sim_ff + t_ri - t_ir;
               end
               if (k_ff == NMAX) state_ff <= S_MUL_WR;
               else begin
                  k_ff <= k_ff + 1'b1;
                  state_ff <= S_MUL_RD;
               end
            end
            S_MUL_WR: begin
               sre_ff <= '0; sim_ff <= '0; k_ff <= '0;
               if (j_ff == NMAX) begin
                  j_ff <= '0;
                  if (i_ff == NMAX) begin
                     i_ff <= '0;
                     // after Y = P U advance to the Hermitian part
                     state_ff <= pass_ff ? S_HRD_A : S_MUL_RD;
                     pass_ff <= ~pass_ff;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                     state_ff <= S_MUL_RD;
                  end
               end else begin
                  j_ff <= j_ff + 1'b1;
                  state_ff <= S_MUL_RD;
               end
            end
            S_HRD_A: state_ff <= S_HRD_B;
            S_HRD_B: begin
               a_ff <= m_rd_ff;
               state_ff <= S_HCALC;
            end
            S_HCALC: begin
               h_ff.re <= sat32(hre_w);
               h_ff.im <= sat32(him_w);
               state_ff <= S_HWR;
            end
            S_HWR: begin
               // hold H in the partial store slot; emit after all are formed
               if (j_ff == NMAX) begin
                  j_ff <= '0;
                  if (i_ff == NMAX) begin
                     i_ff <= '0;
                     state_ff <= S_ERD;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                     state_ff <= S_HRD_A;
                  end
               end else begin
                  j_ff <= j_ff + 1'b1;
                  state_ff <= S_HRD_A;
               end
            end
            S_ERD: state_ff <= S_EMIT;
            S_EMIT: begin
               if (!rsp_tvalid) begin
                  rsp_tvalid <= 1'b1;
                  rsp_tdata  <= RSP_DATA_W'({p_rd_ff.im, p_rd_ff.re, 2'(j_ff), 2'(i_ff),
                                             3'(idx_ff), set_ff});
                  rsp_tlast  <= (i_ff == NMAX) && (j_ff == NMAX);
               end else if (rsp_tready) begin
                  rsp_tvalid <= 1'b0;
                  if (j_ff == NMAX) begin
                     j_ff <= '0;
                     if (i_ff == NMAX) begin
                        i_ff <= '0;
                        state_ff <= S_IDLE;
                     end else begin
                        i_ff <= i_ff + 1'b1;
                        state_ff <= S_ERD;
                     end
                  end else begin
                     j_ff <= j_ff + 1'b1;
                     state_ff <= S_ERD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- test/tb_unitary_similarity_hermitianize.sv -----
// Self-checking testbench of the unitary similarity hermitianize block.
`default_nettype none
module tb_unitary_similarity_hermitianize;
   timeunit 1ns;
   timeprecision 1ps;
   import ushz_pkg::*;

   localparam int N       = 4;
   localparam int SETS_N  = 8;
   localparam int FRAC    = 24;
   localparam int SQ      = N * N;
   localparam int RANDOM_ITEMS = 200;

   typedef struct {
      action_type       act;
      logic             set;
      logic [2:0]       idx;
      logic [1:0]       row;
      logic [1:0]       col;
      logic signed [31:0] re;
      logic signed [31:0] im;
   } request_type;

   typedef struct {
      logic             set;
      logic [2:0]       idx;
      logic [1:0]       row;
      logic [1:0]       col;
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic             last;
   } entry_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   // Shadow copies of the transform and matrix banks.
   cval_type u_shadow[SQ];
   cval_type m_shadow[2*SETS_N*SQ];
   entry_type pending_entries[$];
   int errors = 0;
   int burst_left = 0;

   unitary_similarity_hermitianize i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

   // Product of two Q7.24 parts, rounded to FRAC fraction bits (floor of p + half).
   function automatic longint round_product(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return (p + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic logic signed [31:0] clip32(longint x);
      if (x > longint'(32'sh7fffffff)) return 32'sh7fffffff;
      if (x < -longint'(64'sh80000000)) return 32'sh80000000;
      return x[31:0];
   endfunction

   // Update the shadow banks for one transaction and queue the entries it emits.
   task automatic predict_request(request_type r);
      cval_type p[SQ];
      cval_type y[SQ];
      cval_type a, b, h;
      longint sre, sim;
      int base;
      entry_type e;
      base = (int'(r.set) * SETS_N + int'(r.idx)) * SQ;
      case (r.act)
         ACT_LOAD_U: begin
            u_shadow[r.row*N + r.col] = '{im: r.im, re: r.re};
            return;
         end
         ACT_WRITE_M: begin
            m_shadow[base + r.row*N + r.col] = '{im: r.im, re: r.re};
            return;
         end
         ACT_XFORM: begin
            // P = U^H M
            for (int i = 0; i < N; i++)
               for (int j = 0; j < N; j++) begin
                  sre = 0; sim = 0;
                  for (int k = 0; k < N; k++) begin
                     a = u_shadow[k*N + i];
                     b = m_shadow[base + k*N + j];
                     sre += round_product(a.re, b.re) + round_product(a.im, b.im);
                     sim += round_product(a.re, b.im) - round_product(a.im, b.re);
                  end
                  p[i*N + j] = '{im: clip32(sim), re: clip32(sre)};
               end
            // Y = P U
            for (int i = 0; i < N; i++)
               for (int j = 0; j < N; j++) begin
                  sre = 0; sim = 0;
                  for (int k = 0; k < N; k++) begin
                     a = p[i*N + k];
                     b = u_shadow[k*N + j];
                     sre += round_product(a.re, b.re) - round_product(a.im, b.im);
                     sim += round_product(a.re, b.im) + round_product(a.im, b.re);
                  end
                  y[i*N + j] = '{im: clip32(sim), re: clip32(sre)};
               end
         end
         default: begin
            for (int i = 0; i < SQ; i++) y[i] = m_shadow[base + i];
         end
      endcase
      // Hermitian part, written back in row-major order.
      for (int i = 0; i < N; i++)
         for (int j = 0; j < N; j++) begin
            a = y[i*N + j];
            b = y[j*N + i];
            h.re = clip32((longint'(a.re) + longint'(b.re) + 1) >>> 1);
            h.im = clip32((longint'(a.im) - longint'(b.im) + 1) >>> 1);
            m_shadow[base + i*N + j] = h;
            e.set = r.set; e.idx = r.idx; e.row = i[1:0]; e.col = j[1:0];
            e.re = h.re; e.im = h.im;
            e.last = (i == N-1) && (j == N-1);
            pending_entries.push_back(e);
         end
   endtask

   // Offer one transaction; the sender sometimes idles between bursts of random length.
   task automatic send_request(request_type r);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, r.im, r.re, r.col, r.row, r.idx, r.set, r.act};
      do @(posedge clock); while (!req_tready);
      predict_request(r);
   endtask

   // Value mix: mostly moderate Q7.24 values, some raw words, some extremes, zero and one.
   function automatic logic signed [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      if (sel < 8) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'sh0;
         default: return 32'sh0100_0000;
      endcase
   endfunction

   // Receiver: rotate through stall patterns, with one long hold-off.
   initial begin
      int cyc;
      int hold;
      cyc = 0;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc == 4000) hold = 700;
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            case ((cyc / 500) % 3)
               0: rsp_tready <= (cyc % 11) >= 3;
               1: rsp_tready <= $urandom_range(0, 9) >= 3;
               default: rsp_tready <= 1'b1;
            endcase
         end
      end
   end

   // Compare every accepted entry with the oldest prediction.
   always @(posedge clock) begin
      entry_type e;
      logic [RSP_DATA_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_entries.size() == 0) begin
            $display("%0t: unexpected entry %h last %b", $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            e = pending_entries.pop_front();
            want = {e.im, e.re, e.col, e.row, e.idx, e.set};
            if (rsp_tdata[0] !== e.set || rsp_tdata[3:1] !== e.idx ||
                rsp_tdata[5:4] !== e.row || rsp_tdata[7:6] !== e.col ||
                rsp_tdata[39:8] !== e.re || rsp_tdata[71:40] !== e.im ||
                rsp_tlast !== e.last) begin
               $display("%0t: mismatch expected %h last %b actual %h last %b",
                        $time, want, e.last, rsp_tdata, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Directed rows: extremes of every field, every action, saturation paths.
   request_type directed_rows[] = '{
      '{ACT_WRITE_M, 1'b0, 3'd7, 2'd0, 2'd0, 32'sh7fffffff, 32'sh7fffffff},
      '{ACT_WRITE_M, 1'b0, 3'd7, 2'd0, 2'd1, 32'sh80000000, 32'sh7fffffff},
      '{ACT_WRITE_M, 1'b0, 3'd7, 2'd1, 2'd0, 32'sh7fffffff, 32'sh80000000},
      '{ACT_WRITE_M, 1'b0, 3'd7, 2'd3, 2'd3, 32'sh80000000, 32'sh80000000},
      '{ACT_HERM,    1'b0, 3'd7, 2'd0, 2'd0, 32'sh0, 32'sh0},
      '{ACT_HERM,    1'b1, 3'd0, 2'd3, 2'd3, 32'sh7fffffff, 32'sh80000000},
      '{ACT_WRITE_M, 1'b1, 3'd7, 2'd3, 2'd0, 32'sh80000000, 32'sh7fffffff},
      '{ACT_WRITE_M, 1'b1, 3'd7, 2'd0, 2'd3, 32'sh7fffffff, 32'sh7fffffff},
      '{ACT_LOAD_U,  1'b1, 3'd7, 2'd0, 2'd0, 32'sh7fffffff, 32'sh80000000},
      '{ACT_LOAD_U,  1'b0, 3'd0, 2'd3, 2'd3, 32'sh80000000, 32'sh7fffffff},
      '{ACT_LOAD_U,  1'b1, 3'd3, 2'd1, 2'd2, 32'sh0, 32'sh0},
      '{ACT_XFORM,   1'b0, 3'd7, 2'd0, 2'd0, 32'sh0, 32'sh0},
      '{ACT_XFORM,   1'b1, 3'd7, 2'd3, 2'd3, 32'shffffffff, 32'shffffffff},
      '{ACT_WRITE_M, 1'b1, 3'd3, 2'd2, 2'd1, 32'sh0100_0000, 32'shff00_0000},
      '{ACT_HERM,    1'b1, 3'd3, 2'd0, 2'd0, 32'sh0, 32'sh0},
      '{ACT_HERM,    1'b1, 3'd3, 2'd0, 2'd0, 32'sh0, 32'sh0},
      '{ACT_XFORM,   1'b0, 3'd0, 2'd0, 2'd0, 32'sh0, 32'sh0}
   };

   initial begin
      request_type r;
      int sel;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill U and every matrix first so no entry is ever read unwritten.
      for (int i = 0; i < SQ; i++) begin
         r = '{ACT_LOAD_U, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
               2'(i / N), 2'(i % N), pick_value(), pick_value()};
         send_request(r);
      end
      for (int i = 0; i < 2*SETS_N*SQ; i++) begin
         r = '{ACT_WRITE_M, 1'(i / (SETS_N*SQ)), 3'((i / SQ) % SETS_N),
               2'((i % SQ) / N), 2'(i % N), pick_value(), pick_value()};
         send_request(r);
      end

      // Walk the directed table.
      foreach (directed_rows[i]) send_request(directed_rows[i]);

      // Random part: every action with random content.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sel = $urandom_range(0, 19);
         r.act = (sel < 8) ? ACT_WRITE_M : (sel < 12) ? ACT_LOAD_U :
                 (sel < 16) ? ACT_HERM : ACT_XFORM;
         r.set = 1'($urandom_range(0, 1));
         r.idx = 3'($urandom_range(0, 7));
         r.row = 2'($urandom_range(0, 3));
         r.col = 2'($urandom_range(0, 3));
         r.re  = pick_value();
         r.im  = pick_value();
         send_request(r);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain, then hold a little past the last entry for stragglers.
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0 && pending_entries.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
